/* hdl/ptm_pkg.sv */
// Shared types, constants and the microcode program of the page table mapper.
package ptm_pkg;

	localparam int IDX_W   = 9;
	localparam int ENTRIES = 512;
	localparam int VP_W    = 36;
	localparam int PF_W    = 40;
	localparam int ENTRY_W = 64;
	localparam int CFG_W   = 7;
	localparam int ROOT_W  = 6;
	localparam int STEP_W  = 4;

	localparam logic [1:0] LEAF_LEVEL = 2'd3;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_ROOT_FRAME       = 1'b0;
	localparam cfg_idx_t REG_FIRST_FREE_FRAME = 1'b1;

	typedef struct packed {
		logic [VP_W-1:0] virt_page;
		logic [PF_W-1:0] phys_frame;
	} req_item_t;

	typedef struct packed {
		logic       status;
		logic [1:0] tables_created;
	} rsp_item_t;

	typedef logic [STEP_W-1:0] step_t;
	localparam step_t ST_SWEEP  = 4'd0;
	localparam step_t ST_IDLE   = 4'd1;
	localparam step_t ST_MODW   = 4'd2;
	localparam step_t ST_RD     = 4'd3;
	localparam step_t ST_RDW    = 4'd4;
	localparam step_t ST_CHK    = 4'd5;
	localparam step_t ST_ALLOC  = 4'd6;
	localparam step_t ST_CLR    = 4'd7;
	localparam step_t ST_LINK   = 4'd8;
	localparam step_t ST_FOLLOW = 4'd9;
	localparam step_t ST_LEAF   = 4'd10;
	localparam step_t ST_FAIL   = 4'd11;
	localparam step_t ST_DONE   = 4'd12;

	typedef enum logic [3:0] {
		A_NONE   = 4'd0,
		A_SWEEP  = 4'd1,
		A_ACCEPT = 4'd2,
		A_TABLE  = 4'd3,
		A_READ   = 4'd4,
		A_ENTRY  = 4'd5,
		A_ALLOC  = 4'd6,
		A_CLEAR  = 4'd7,
		A_LINK   = 4'd8,
		A_FOLLOW = 4'd9,
		A_LEAF   = 4'd10,
		A_FAIL   = 4'd11,
		A_RESULT = 4'd12
	} act_t;

	typedef enum logic [3:0] {
		C_ALWAYS      = 4'd0,
		C_SWEEP_BUSY  = 4'd1,
		C_NO_INPUT    = 4'd2,
		C_MOD_BUSY    = 4'd3,
		C_LEAF        = 4'd4,
		C_PRESENT     = 4'd5,
		C_NO_FRAME    = 4'd6,
		C_CLR_BUSY    = 4'd7,
		C_OUT_BLOCKED = 4'd8
	} cond_t;

	typedef struct packed {
		logic sweep_busy;
		logic no_input;
		logic mod_busy;
		logic leaf;
		logic present;
		logic no_frame;
		logic clr_busy;
		logic out_blocked;
	} flags_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} ctrl_t;

	// One control word per step: action, jump condition, jump target, fall-through step.
	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		unique case (s)
			ST_SWEEP:  c = '{A_SWEEP,  C_SWEEP_BUSY,  ST_SWEEP,  ST_IDLE};
			ST_IDLE:   c = '{A_ACCEPT, C_NO_INPUT,    ST_IDLE,   ST_MODW};
			ST_MODW:   c = '{A_TABLE,  C_MOD_BUSY,    ST_MODW,   ST_RD};
			ST_RD:     c = '{A_READ,   C_ALWAYS,      ST_RDW,    ST_RDW};
			ST_RDW:    c = '{A_ENTRY,  C_LEAF,        ST_LEAF,   ST_CHK};
			ST_CHK:    c = '{A_NONE,   C_PRESENT,     ST_FOLLOW, ST_ALLOC};
			ST_ALLOC:  c = '{A_ALLOC,  C_NO_FRAME,    ST_FAIL,   ST_CLR};
			ST_CLR:    c = '{A_CLEAR,  C_CLR_BUSY,    ST_CLR,    ST_LINK};
			ST_LINK:   c = '{A_LINK,   C_ALWAYS,      ST_RD,     ST_RD};
			ST_FOLLOW: c = '{A_FOLLOW, C_ALWAYS,      ST_MODW,   ST_MODW};
			ST_LEAF:   c = '{A_LEAF,   C_ALWAYS,      ST_DONE,   ST_DONE};
			ST_FAIL:   c = '{A_FAIL,   C_ALWAYS,      ST_DONE,   ST_DONE};
			ST_DONE:   c = '{A_RESULT, C_OUT_BLOCKED, ST_DONE,   ST_IDLE};
			default:   c = '{A_NONE,   C_ALWAYS,      ST_IDLE,   ST_IDLE};
		endcase
		return c;
	endfunction

endpackage

/* hdl/ptm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/ptm_mod.sv */
// 40-bit frame number modulo the frame count, iterative unless a power of two.
module ptm_mod
	import ptm_pkg::*;
#(
	parameter int FRAMES = 64,
	localparam int FW = $clog2(FRAMES)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [PF_W-1:0] value,
	output logic            busy,
	output logic [FW-1:0]   result
);

	localparam bit IS_POW2 = (FRAMES & (FRAMES - 1)) == 0;
	localparam int BITS_PER_STEP = 8;
	localparam int STEPS = PF_W / BITS_PER_STEP;
	localparam logic [FW:0] MODV = (FW + 1)'(FRAMES);

	logic [PF_W-1:0] val_q;
	logic [FW-1:0]   rem_q;
	logic [FW-1:0]   rem_nx;
	logic [2:0]      cnt_q;
	logic            busy_q;

	// Restoring reduction, eight numerator bits per cycle, most significant first.
	always_comb begin
		logic [FW-1:0] r;
		logic [FW:0]   t;
		r = rem_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t = {r, val_q[PF_W-1-i]};
			if (t >= MODV) begin
				t = t - MODV;
			end
			r = t[FW-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !IS_POW2;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << BITS_PER_STEP;
			rem_q <= rem_nx;
		end
	end

	assign busy   = busy_q;
	assign result = IS_POW2 ? val_q[FW-1:0] : rem_q;

endmodule

/* hdl/ptm_seq.sv */
// Microcode sequencer: step counter, control word lookup and conditional jumps.
module ptm_seq
	import ptm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctrl_t  ctrl,
	output logic   idle
);

	step_t step_q;
	logic  take;

	assign ctrl = ucode(step_q);
	assign idle = step_q == ST_IDLE;

	always_comb begin
		unique case (ctrl.cond)
			C_ALWAYS:      take = 1'b1;
			C_SWEEP_BUSY:  take = flags.sweep_busy;
			C_NO_INPUT:    take = flags.no_input;
			C_MOD_BUSY:    take = flags.mod_busy;
			C_LEAF:        take = flags.leaf;
			C_PRESENT:     take = flags.present;
			C_NO_FRAME:    take = flags.no_frame;
			C_CLR_BUSY:    take = flags.clr_busy;
			C_OUT_BLOCKED: take = flags.out_blocked;
			default:       take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_SWEEP;
		end else begin
			step_q <= take ? ctrl.jmp : ctrl.nxt;
		end
	end

endmodule

/* hdl/four_level_page_table_mapper_core.sv */
// Four-level page table mapper: walks and extends tables held in an on-chip frame store.
// After reset the store is swept to zero, one entry a cycle, while req_stall stays high;
// configuration writes are taken during the sweep. One item is in work at a time; the
// next item is taken only after the previous result has been registered. Each new
// table is cleared entry by entry before it is linked; with FRAMES not a power of two
// the reduction of each frame number is iterative.
module four_level_page_table_mapper_core
	import ptm_pkg::*;
#(
	parameter int FRAMES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  cfg_idx_t           cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_item_t          req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_item_t          rsp
);

	// Frame index width, store depth and address width all follow from FRAMES.
	localparam int FW    = $clog2(FRAMES);
	localparam int DEPTH = FRAMES * ENTRIES;
	localparam int AW    = $clog2(DEPTH);
	localparam int UW    = $clog2(FRAMES + 1);
	localparam int CW    = ((UW > CFG_W) ? UW : CFG_W) + 1;

	ctrl_t  ctrl;
	flags_t flags;
	logic   seq_idle;

	// Configuration registers and allocator state.
	logic [ROOT_W-1:0] root_q;
	logic [CFG_W-1:0]  fff_q;
	logic [UW-1:0]     used_q;

	// Walk datapath.
	logic [VP_W-1:0]    vp_q;
	logic [PF_W-1:0]    pf_q;
	logic [FW-1:0]      table_q;
	logic [FW-1:0]      fresh_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [1:0]         level_q;
	logic [1:0]         created_q;
	logic               status_q;
	logic [AW-1:0]      cnt_q;

	// Result register.
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	logic               accepted;
	logic [IDX_W-1:0]   idx;
	logic [CW-1:0]      cand;
	logic               no_frame;
	logic               out_blocked;
	logic               mod_start;
	logic [PF_W-1:0]    mod_value;
	logic               mod_busy;
	logic [FW-1:0]      mod_result;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [PF_W-1:0]    link_frame;

	ptm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl),
		.idle   (seq_idle)
	);

	// The input side is open only while the sequencer sits at its idle step.
	assign req_stall = !seq_idle;
	assign accepted  = req_valid && !req_stall;

	// The table index for the current level comes from nine bits of the virtual page.
	always_comb begin
		unique case (level_q)
			2'd0:    idx = vp_q[35:27];
			2'd1:    idx = vp_q[26:18];
			2'd2:    idx = vp_q[17:9];
			default: idx = vp_q[8:0];
		endcase
	end

	// Bump allocator: the next frame is the first free frame plus the frames handed out.
	assign cand     = CW'(fff_q) + CW'(used_q);
	assign no_frame = cand >= CW'(FRAMES);

	assign out_blocked = rsp_valid_q && rsp_stall;

	assign flags.sweep_busy  = cnt_q != AW'(DEPTH - 1);
	assign flags.no_input    = !req_valid;
	assign flags.mod_busy    = mod_busy;
	assign flags.leaf        = level_q == LEAF_LEVEL;
	assign flags.present     = entry_q[0];
	assign flags.no_frame    = no_frame;
	assign flags.clr_busy    = cnt_q[IDX_W-1:0] != '1;
	assign flags.out_blocked = out_blocked;

	// The root frame and every frame number taken from an entry are reduced modulo FRAMES.
	assign mod_start = (ctrl.act == A_ACCEPT && accepted) || ctrl.act == A_FOLLOW;
	assign mod_value = (ctrl.act == A_FOLLOW) ? entry_q[51:12] : PF_W'(root_q);

	ptm_mod #(
		.FRAMES (FRAMES)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (mod_value),
		.busy   (mod_busy),
		.result (mod_result)
	);

	// Store write port: zero sweep after reset, clearing of a new frame, and the
	// read-modify-write of a link or leaf entry, which keeps the entry's other bits
	// and sets present and writable.
	assign link_frame = (ctrl.act == A_LINK) ? PF_W'(fresh_q) : pf_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {table_q, idx};
		ram_wdata = {entry_q[63:52], link_frame, entry_q[11:2], 2'b11};
		unique case (ctrl.act)
			A_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = '0;
			end
			A_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = {fresh_q, cnt_q[IDX_W-1:0]};
				ram_wdata = '0;
			end
			A_LINK, A_LEAF: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_re = ctrl.act == A_READ;

	ptm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr ({table_q, idx}),
		.rdata (ram_rdata)
	);

	// Control state: configuration, allocator count, counters and the result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q      <= '0;
			fff_q       <= CFG_W'(1);
			used_q      <= '0;
			cnt_q       <= '0;
			level_q     <= '0;
			created_q   <= '0;
			status_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROOT_FRAME:       root_q <= cfg_data[ROOT_W-1:0];
					REG_FIRST_FREE_FRAME: fff_q  <= cfg_data;
					default:              root_q <= root_q;
				endcase
			end
			// A new result may replace one that leaves in the same cycle.
			if (ctrl.act == A_RESULT && !out_blocked) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (ctrl.act)
				A_SWEEP, A_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
				end
				A_ACCEPT: begin
					if (accepted) begin
						level_q   <= '0;
						created_q <= '0;
						status_q  <= 1'b0;
					end
				end
				A_ALLOC: begin
					if (!no_frame) begin
						used_q    <= used_q + UW'(1);
						created_q <= created_q + 2'd1;
						cnt_q     <= '0;
					end
				end
				A_LINK, A_FOLLOW: begin
					level_q <= level_q + 2'd1;
				end
				A_FAIL: begin
					status_q <= 1'b1;
				end
				default: begin
					level_q <= level_q;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (ctrl.act)
			A_ACCEPT: begin
				if (accepted) begin
					vp_q <= req.virt_page;
					pf_q <= req.phys_frame;
				end
			end
			A_TABLE: begin
				table_q <= mod_result;
			end
			A_ENTRY: begin
				entry_q <= ram_rdata;
			end
			A_ALLOC: begin
				fresh_q <= cand[FW-1:0];
			end
			A_LINK: begin
				table_q <= fresh_q;
			end
			A_RESULT: begin
				if (!out_blocked) begin
					rsp_q.status         <= status_q;
					rsp_q.tables_created <= created_q;
				end
			end
			default: begin
				vp_q <= vp_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
